// ===== rtl/path_nearest_point_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// path nearest point tracker assertion macros
// shared property shapes for the tracker's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PATH_NEAREST_POINT_TRACKER_UNIT_MACROS_SVH
`define PATH_NEAREST_POINT_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PNPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PNPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pnpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pnpt_pkg
// command and status codes, controller states and fixed field widths
// ----------------------------------------------------------------------------
package pnpt_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int WIN_W    = 10;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 11;

   localparam logic [CMD_W-1:0] CMD_NEW_PATH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/path_nearest_point_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// path_nearest_point_tracker_unit
// path point store with a monotonic progress index and nearest point search
//
//   channel   handshake            payload
//   request   start / busy         req_cmd, req_pos_x, req_pos_y
//   response  rsp_strobe (1 cycle) rsp_track_index, rsp_path_length, rsp_status
//   csr       csr_wr_en            csr_wr_data (backtrack window)
//
// new-path, append and unused commands respond in the cycle after acceptance
// and never raise busy. a query on a non-empty path reads N = count - begin
// points from the store, one per cycle through its single read port, and
// holds busy until the pipe drains; an empty-path query responds next cycle.
// reset clears count, progress and window; the store itself is not cleared
// and needs no sweep. the response is shown once and cannot be stalled.
// ----------------------------------------------------------------------------
`include "path_nearest_point_tracker_unit_macros.svh"

module path_nearest_point_tracker_unit
   import pnpt_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   output logic                  rsp_strobe,
   output logic [INDEX_W-1:0]    rsp_track_index,
   output logic [LENGTH_W-1:0]   rsp_path_length,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_wr_en,
   input  logic [WIN_W-1:0]      csr_wr_data
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int CMP_W  = (IDX_W > WIN_W) ? IDX_W : WIN_W;
   localparam int PT_W   = 2 * COORD_BITS;
   localparam int SQ_W   = 2 * (COORD_BITS + 1);
   localparam int SUM_W  = SQ_W + 1;

   // path store
   logic [PT_W-1:0] mem [MAX_POINTS];
   logic            mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic            rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [PT_W-1:0] rd_data_ff;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] progress_ff, progress_in;
   logic [WIN_W-1:0] win_ff;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic signed [COORD_BITS-1:0] rx_ff, ry_ff;

   logic             s1_ff;
   logic [IDX_W-1:0] idx1_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic             have_ff, have_in;
   logic [SUM_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   logic             accept;
   logic             dist_valid;
   logic [IDX_W-1:0] dist_index;
   logic [SQ_W-1:0]  sq_x, sq_y;
   logic             pipe_active;
   logic [SUM_W-1:0] dist_sum;
   logic [CMP_W-1:0] prev_cmp, win_cmp;
   logic [IDX_W-1:0] begin_idx;
   logic [IDX_W-1:0] count_last;
   logic [IDX_W-1:0] new_progress;
   logic             drain_done;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {req_pos_x, req_pos_y};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
      end else begin
         s1_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= rd_addr;
   end

   pnpt_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_ff),
      .in_index    (idx1_ff),
      .pt_x        ($signed(rd_data_ff[PT_W-1:COORD_BITS])),
      .pt_y        ($signed(rd_data_ff[COORD_BITS-1:0])),
      .ref_x       (rx_ff),
      .ref_y       (ry_ff),
      .out_valid   (dist_valid),
      .out_index   (dist_index),
      .sq_x        (sq_x),
      .sq_y        (sq_y),
      .pipe_active (pipe_active)
   );

   always_comb begin
      dist_sum     = {1'b0, sq_x} + {1'b0, sq_y};
      prev_cmp     = CMP_W'(prev_ff);
      win_cmp      = CMP_W'(win_ff);
      begin_idx    = (prev_cmp > win_cmp) ? IDX_W'(prev_cmp - win_cmp) : '0;
      count_last   = IDX_W'(count_ff - 1'b1);
      new_progress = (best_idx_ff > prev_ff) ? best_idx_ff : prev_ff;
      drain_done   = !s1_ff && !pipe_active && !dist_valid;
   end

   // running minimum, ties keep the earliest point
   always_comb begin
      have_in     = have_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (state_ff == ST_SETUP) begin
         have_in = 1'b0;
      end else if (dist_valid && (!have_ff || dist_sum < best_ff)) begin
         have_in     = 1'b1;
         best_in     = dist_sum;
         best_idx_in = dist_index;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      progress_in   = progress_ff;
      prev_in       = prev_ff;
      last_in       = last_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = INDEX_W'(progress_ff);
      rsp_length_in = LENGTH_W'(count_ff);
      rsp_status_in = STATUS_OK;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      rd_en         = 1'b0;
      rd_addr       = scan_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_NEW_PATH: begin
                     mem_we        = 1'b1;
                     count_in      = CNT_W'(1);
                     progress_in   = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_index_in  = '0;
                     rsp_length_in = LENGTH_W'(1);
                  end
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        mem_we        = 1'b1;
                        mem_waddr     = IDX_W'(count_ff);
                        count_in      = count_ff + 1'b1;
                        rsp_length_in = LENGTH_W'(count_ff + 1'b1);
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_index_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        last_in  = count_last;
                        prev_in  = (progress_ff > count_last) ? count_last : progress_ff;
                        state_in = ST_SETUP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            scan_in  = begin_idx;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (scan_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               progress_in  = new_progress;
               rsp_valid_in = 1'b1;
               rsp_index_in = INDEX_W'(new_progress);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         progress_ff  <= '0;
         win_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         progress_ff  <= progress_in;
         rsp_valid_ff <= rsp_valid_in;
         have_ff      <= have_in;
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      last_ff       <= last_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         rx_ff <= $signed(req_pos_x);
         ry_ff <= $signed(req_pos_y);
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_track_index = rsp_index_ff;
   assign rsp_path_length = rsp_length_ff;
   assign rsp_status      = rsp_status_ff;

   `PNPT_ASSERT_IMPLY(a_no_rsp_in_scan, clock, reset, state_ff == ST_SCAN, !rsp_valid_ff, "response during scan")
   `PNPT_ASSERT_IMPLY(a_progress_in_path, clock, reset, count_ff != '0, CNT_W'(progress_ff) < count_ff, "progress past path end")
   `PNPT_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS), "point count over capacity")
   `PNPT_ASSERT_IMPLY(a_pipe_in_query, clock, reset, dist_valid, state_ff == ST_SCAN || state_ff == ST_DRAIN, "distance result outside query")
   `PNPT_ASSERT_NEXT(a_finish_idle, clock, reset, state_ff == ST_DRAIN && drain_done, rsp_valid_ff && state_ff == ST_IDLE, "query finish lost")

endmodule

// ===== rtl/pnpt_dist.sv =====
// ----------------------------------------------------------------------------
// pnpt_dist
// two-stage squared distance pipe: absolute differences, then squares
// ----------------------------------------------------------------------------
module pnpt_dist
   import pnpt_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int IDX_W      = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [IDX_W-1:0]             in_index,
   input  logic signed [COORD_BITS-1:0] pt_x,
   input  logic signed [COORD_BITS-1:0] pt_y,
   input  logic signed [COORD_BITS-1:0] ref_x,
   input  logic signed [COORD_BITS-1:0] ref_y,
   output logic                         out_valid,
   output logic [IDX_W-1:0]             out_index,
   output logic [2*COORD_BITS+1:0]      sq_x,
   output logic [2*COORD_BITS+1:0]      sq_y,
   output logic                         pipe_active
);

   localparam int DW   = COORD_BITS + 1;
   localparam int SQ_W = 2 * DW;

   logic signed [DW-1:0] diff_x;
   logic signed [DW-1:0] diff_y;
   logic [DW-1:0]        mag_x;
   logic [DW-1:0]        mag_y;

   logic                 a_valid_ff;
   logic [IDX_W-1:0]     a_index_ff;
   logic [DW-1:0]        ax_ff;
   logic [DW-1:0]        ay_ff;

   logic                 b_valid_ff;
   logic [IDX_W-1:0]     b_index_ff;
   logic [SQ_W-1:0]      sqx_ff;
   logic [SQ_W-1:0]      sqy_ff;

   always_comb begin
      diff_x = $signed({pt_x[COORD_BITS-1], pt_x}) - $signed({ref_x[COORD_BITS-1], ref_x});
      diff_y = $signed({pt_y[COORD_BITS-1], pt_y}) - $signed({ref_y[COORD_BITS-1], ref_y});
      // most negative difference wraps to its true magnitude as unsigned
      mag_x  = diff_x[DW-1] ? (~diff_x + 1'b1) : diff_x;
      mag_y  = diff_y[DW-1] ? (~diff_y + 1'b1) : diff_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_index_ff <= in_index;
      ax_ff      <= mag_x;
      ay_ff      <= mag_y;
      b_index_ff <= a_index_ff;
      sqx_ff     <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sqy_ff     <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
   end

   assign out_valid   = b_valid_ff;
   assign out_index   = b_index_ff;
   assign sq_x        = sqx_ff;
   assign sq_y        = sqy_ff;
   assign pipe_active = a_valid_ff | b_valid_ff;

endmodule

// ===== sim/tb_path_nearest_point_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_path_nearest_point_tracker_unit
// drives new-path, append, query and unused commands through the start/busy
// port, tracks path points, point count, progress and backtrack window in a
// scoreboard, and checks every strobed response against its prediction
// ----------------------------------------------------------------------------
module tb_path_nearest_point_tracker_unit
   import pnpt_pkg::*;
();

   localparam int COORD_W     = 24;
   localparam int PATH_DEPTH  = 1024;
   localparam int LONG_PATH   = 150;
   localparam int STALL_LIMIT = 8000;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  track_index;
      logic [LENGTH_W-1:0] path_length;
      logic [STATUS_W-1:0] status;
   } response_type;

   class path_tracker_board_type;
      coord_type    pt_x [PATH_DEPTH];
      coord_type    pt_y [PATH_DEPTH];
      int unsigned  point_count;
      int unsigned  progress;
      int unsigned  window;
      response_type pending_responses [$];
      int unsigned  mismatch_count;
      int unsigned  request_count;
      int unsigned  query_count;
      int unsigned  empty_query_count;
      int unsigned  dropped_count;
      int unsigned  window_writes;

      function new();
         point_count       = 0;
         progress          = 0;
         window            = 0;
         mismatch_count    = 0;
         request_count     = 0;
         query_count       = 0;
         empty_query_count = 0;
         dropped_count     = 0;
         window_writes     = 0;
      endfunction

      function void set_window(logic [WIN_W-1:0] value);
         window = value;
         window_writes++;
      endfunction

      function longint sq_distance(int unsigned i, coord_type rx, coord_type ry);
         longint dx;
         longint dy;
         dx = longint'(pt_x[i]) - longint'(rx);
         dy = longint'(pt_y[i]) - longint'(ry);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         return dx * dx + dy * dy;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, coord_type x, coord_type y);
         response_type r;
         int unsigned  prev;
         int unsigned  first;
         int unsigned  best;
         longint       d;
         longint       best_d;
         r.status = STATUS_OK;
         request_count++;
         case (cmd)
            CMD_NEW_PATH: begin
               pt_x[0]     = x;
               pt_y[0]     = y;
               point_count = 1;
               progress    = 0;
            end
            CMD_APPEND: begin
               if (point_count < PATH_DEPTH) begin
                  pt_x[point_count] = x;
                  pt_y[point_count] = y;
                  point_count++;
               end else begin
                  r.status = STATUS_FULL;
                  dropped_count++;
               end
            end
            CMD_QUERY: begin
               query_count++;
               if (point_count == 0) begin
                  r.status = STATUS_EMPTY;
                  empty_query_count++;
               end else begin
                  prev   = (progress > point_count - 1) ? point_count - 1 : progress;
                  first  = (prev > window) ? prev - window : 0;
                  best   = first;
                  best_d = sq_distance(first, x, y);
                  // strict compare keeps the earliest of equal distances
                  for (int unsigned i = first + 1; i < point_count; i++) begin
                     d = sq_distance(i, x, y);
                     if (d < best_d) begin
                        best_d = d;
                        best   = i;
                     end
                  end
                  progress = (best > prev) ? best : prev;
               end
            end
            default: ;
         endcase
         if (cmd == CMD_QUERY && point_count == 0)
            r.track_index = '0;
         else
            r.track_index = INDEX_W'(progress);
         r.path_length = LENGTH_W'(point_count);
         pending_responses.push_back(r);
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: response idx=%0d len=%0d status=%0d with no request pending",
                        got.track_index, got.path_length, got.status);
            return;
         end
         want = pending_responses.pop_front();
         if (got.track_index !== want.track_index || got.path_length !== want.path_length ||
             got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: idx %0d/%0d len %0d/%0d status %0d/%0d (expected/actual)",
                        want.track_index, got.track_index, want.path_length,
                        got.path_length, want.status, got.status);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd;
   coord_type           req_pos_x;
   coord_type           req_pos_y;
   logic                rsp_strobe;
   logic [INDEX_W-1:0]  rsp_track_index;
   logic [LENGTH_W-1:0] rsp_path_length;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_wr_en;
   logic [WIN_W-1:0]    csr_wr_data;

   path_tracker_board_type board = new();
   int unsigned            idle_pct;
   int unsigned            quiet_cycles;

   path_nearest_point_tracker_unit #(
      .MAX_POINTS (PATH_DEPTH),
      .COORD_BITS (COORD_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_track_index (rsp_track_index),
      .rsp_path_length (rsp_path_length),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      bit           moved;
      response_type got;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en === 1'b1)
            board.set_window(csr_wr_data);
         if (rsp_strobe === 1'b1) begin
            got = '{rsp_track_index, rsp_path_length, rsp_status};
            board.check_response(got);
            moved = 1'b1;
         end
         if (start === 1'b1 && busy === 1'b0) begin
            board.note_request(req_cmd, req_pos_x, req_pos_y);
            moved = 1'b1;
         end
         if (moved)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("[path_nearest_point_tracker_unit] ERROR");
            $finish;
         end
      end
   end

   function automatic coord_type rand_coord();
      case ($urandom_range(15))
         0:       return coord_type'(24'h7FFFFF);
         1:       return coord_type'(24'h800000);
         2:       return '0;
         3:       return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // request stays up across back-to-back items, dropped only for idle cycles
   task automatic send_request(input logic [CMD_W-1:0] cmd, input coord_type x,
                               input coord_type y);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start     = 1'b1;
      req_cmd   = cmd;
      req_pos_x = x;
      req_pos_y = y;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic send_query(input int unsigned spread);
      int unsigned j;
      int          ox;
      int          oy;
      j  = $urandom_range(board.point_count - 1);
      ox = int'($urandom_range(2 * spread)) - int'(spread);
      oy = int'($urandom_range(2 * spread)) - int'(spread);
      case ($urandom_range(9))
         0:       send_request(CMD_QUERY, rand_coord(), rand_coord());
         1:       send_request(CMD_QUERY, board.pt_x[j], board.pt_y[j]);
         default: send_request(CMD_QUERY, coord_type'(board.pt_x[j] + ox),
                               coord_type'(board.pt_y[j] + oy));
      endcase
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      start = 1'b0;
      while (board.pending_responses.size() != 0 || busy !== 1'b0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // walked paths with queries mixed in, plus some stray commands
   task automatic run_paths(input int unsigned budget, input int unsigned max_len);
      int unsigned sent;
      int unsigned len;
      int unsigned step;
      coord_type   cx;
      coord_type   cy;
      sent = 0;
      while (sent < budget) begin
         cx = rand_coord();
         cy = rand_coord();
         send_request(CMD_NEW_PATH, cx, cy);
         sent++;
         len  = ($urandom_range(11) == 0) ? $urandom_range(40, max_len) : $urandom_range(0, 20);
         // tight steps make equal distances common
         step = ($urandom_range(3) == 0) ? 2 : 3000;
         repeat (len) begin
            if ($urandom_range(99) < 8) begin
               send_request(CMD_W'($urandom_range(3)), rand_coord(), rand_coord());
            end else begin
               cx = coord_type'(cx + (int'($urandom_range(2 * step)) - int'(step)));
               cy = coord_type'(cy + (int'($urandom_range(2 * step)) - int'(step)));
               send_request(CMD_APPEND, cx, cy);
            end
            sent++;
            if ($urandom_range(99) < 35) begin
               send_query(step);
               sent++;
            end
         end
         repeat ($urandom_range(1, 3)) begin
            send_query(step);
            sent++;
         end
      end
   endtask

   // one long path under the widest window, then the narrowest
   task automatic long_path();
      coord_type cx;
      coord_type cy;
      write_window(10'd1023);
      cx = rand_coord();
      cy = rand_coord();
      send_request(CMD_NEW_PATH, cx, cy);
      for (int i = 1; i < LONG_PATH; i++) begin
         cx = coord_type'(cx + (int'($urandom_range(6000)) - 3000));
         cy = coord_type'(cy + (int'($urandom_range(6000)) - 3000));
         send_request(CMD_APPEND, cx, cy);
         if (i % 50 == 0)
            send_query(500);
      end
      send_query(0);
      send_request(CMD_QUERY, board.pt_x[LONG_PATH-1], board.pt_y[LONG_PATH-1]);
      send_request(CMD_QUERY, board.pt_x[0], board.pt_y[0]);
      write_window(10'd0);
      send_request(CMD_QUERY, board.pt_x[0], board.pt_y[0]);
      send_request(CMD_APPEND, rand_coord(), rand_coord());
      send_request(CMD_NEW_PATH, '0, '0);
      send_request(CMD_QUERY, rand_coord(), rand_coord());
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_cmd     = CMD_NEW_PATH;
      req_pos_x   = '0;
      req_pos_y   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_pct    = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: empty path, extremes, ties and the unused command
      write_window(10'd2);
      send_request(CMD_QUERY, '0, '0);
      send_request(CMD_APPEND, coord_type'(24'h800000), coord_type'(24'h7FFFFF));
      send_request(CMD_UNUSED, '1, '1);
      send_request(CMD_QUERY, coord_type'(24'h7FFFFF), coord_type'(24'h800000));
      send_request(CMD_NEW_PATH, coord_type'(24'h7FFFFF), coord_type'(24'h800000));
      send_request(CMD_APPEND, coord_type'(24'h800000), coord_type'(24'h7FFFFF));
      send_request(CMD_APPEND, '0, '0);
      send_request(CMD_APPEND, '0, '0);
      send_request(CMD_QUERY, coord_type'(24'h800000), coord_type'(24'h7FFFFF));
      send_request(CMD_QUERY, '0, '0);
      send_request(CMD_QUERY, coord_type'(24'h7FFFFF), coord_type'(24'h800000));
      send_request(CMD_UNUSED, '0, '0);
      send_request(CMD_APPEND, 24'sd1, 24'sd1);
      send_request(CMD_APPEND, -24'sd1, -24'sd1);
      send_request(CMD_QUERY, '0, '0);
      send_request(CMD_QUERY, -24'sd1, -24'sd1);

      idle_pct = 27;
      write_window(10'd1023);
      run_paths(45, 120);
      write_window(10'd0);
      run_paths(45, 120);

      idle_pct = 76;
      write_window(10'd5);
      run_paths(45, 120);
      write_window(10'd1);
      run_paths(45, 120);

      idle_pct = 0;
      write_window(WIN_W'($urandom_range(1, 1022)));
      run_paths(45, 120);
      write_window(10'd700);
      run_paths(45, 120);
      long_path();

      start = 1'b0;
      while (board.pending_responses.size() != 0 || busy !== 1'b0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("run covered %0d requests: %0d queries, %0d on an empty path, %0d dropped appends",
               board.request_count, board.query_count, board.empty_query_count,
               board.dropped_count);
      $display("window written %0d times, %0d mismatches seen",
               board.window_writes, board.mismatch_count);
      if (board.mismatch_count == 0 && board.pending_responses.size() == 0)
         $display("[path_nearest_point_tracker_unit] OK");
      else
         $display("[path_nearest_point_tracker_unit] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pnpt_pkg.sv
rtl/pnpt_dist.sv
rtl/path_nearest_point_tracker_unit.sv
sim/tb_path_nearest_point_tracker_unit.sv
